/* rtl/core/rqcf_pkg.sv */
// Shared types, constants and the feature slot table for the contact feature core.
package rqcf_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int NUM_LANES = 4;
   localparam int NUM_SLOTS = 25;
   localparam int SLOT_CORNER_BASE = 4;
   localparam int SLOT_CROSS_BASE = 8;
   localparam int SLOT_NONE = 24;

   localparam logic [1:0] KIND_QUAD = 2'd0;
   localparam logic [1:0] KIND_CORNER = 2'd1;
   localparam logic [1:0] KIND_CROSS = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      logic en_a;
      logic en_b;
      logic en_c;
   } pipe_en_type;

   typedef struct packed {
      logic [3:0] side;
      logic [3:0] edge_ok;
   } lane_res_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] quad_index;
      logic [1:0] rect_index;
   } slot_type;

   // Slot order: quad vertices 3..0, corners 0..3, crossings by edge r then q = 3..0, none.
   function automatic slot_type slot_info(input logic [4:0] s);
      logic [4:0] k;
      logic [1:0] q;
      slot_type t;
      k = s - 5'(SLOT_CROSS_BASE);
      q = 2'd3 - k[1:0];
      t.kind = KIND_NONE;
      t.quad_index = 2'd0;
      t.rect_index = 2'd0;
      if (s < 5'(SLOT_CORNER_BASE)) begin
         t.kind = KIND_QUAD;
         t.quad_index = 2'd3 - s[1:0];
      end else if (s < 5'(SLOT_CROSS_BASE)) begin
         t.kind = KIND_CORNER;
         t.rect_index = s[1:0];
      end else if (s < 5'(SLOT_NONE)) begin
         t.kind = KIND_CROSS;
         t.quad_index = q + 2'd3;
         t.rect_index = k[3:2];
      end
      return t;
   endfunction

endpackage

/* rtl/core/rqcf_lane.sv */
// One quad-edge lane: side tests and the four corner cross-product signs for vertex q.
module rqcf_lane #(
   parameter int COORD_WIDTH = rqcf_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  rqcf_pkg::pipe_en_type         en,
   input  logic signed [COORD_WIDTH-1:0] qx,
   input  logic signed [COORD_WIDTH-1:0] qy,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  logic        [COORD_WIDTH-2:0] hx,
   input  logic        [COORD_WIDTH-2:0] hy,
   output rqcf_pkg::lane_res_type        res
);
   import rqcf_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] qxe, qye, hxe, hye;
   logic signed [DW-1:0] rx [4];
   logic signed [DW-1:0] ry [4];

   logic signed [DW-1:0] dqx_ff, dqy_ff;
   logic signed [DW-1:0] drx_ff [4];
   logic signed [DW-1:0] dry_ff [4];
   logic [3:0]           side_a_ff, side_a_in;
   logic signed [PW-1:0] pl_ff [4];
   logic signed [PW-1:0] pr_ff [4];
   logic [3:0]           side_b_ff;
   logic [3:0]           side_c_ff;
   logic [3:0]           edge_c_ff;

   assign qxe = DW'(qx);
   assign qye = DW'(qy);
   assign hxe = $signed({1'b0, 1'b0, hx});
   assign hye = $signed({1'b0, 1'b0, hy});

   always_comb begin
      rx[0] = hxe;  ry[0] = hye;
      rx[1] = -hxe; ry[1] = hye;
      rx[2] = -hxe; ry[2] = -hye;
      rx[3] = hxe;  ry[3] = -hye;
      side_a_in[0] = qye <= hye;
      side_a_in[1] = qxe >= -hxe;
      side_a_in[2] = qye >= -hye;
      side_a_in[3] = qxe <= hxe;
   end

   always_ff @(posedge clock) begin
      if (en.en_a) begin
         dqx_ff <= DW'(px) - qxe;
         dqy_ff <= DW'(py) - qye;
         side_a_ff <= side_a_in;
         for (int r = 0; r < 4; r++) begin
            drx_ff[r] <= rx[r] - qxe;
            dry_ff[r] <= ry[r] - qye;
         end
      end
      if (en.en_b) begin
         side_b_ff <= side_a_ff;
         for (int r = 0; r < 4; r++) begin
            pl_ff[r] <= dqx_ff * dry_ff[r];
            pr_ff[r] <= dqy_ff * drx_ff[r];
         end
      end
      if (en.en_c) begin
         side_c_ff <= side_b_ff;
         for (int r = 0; r < 4; r++) begin
            edge_c_ff[r] <= pl_ff[r] >= pr_ff[r];
         end
      end
   end

   assign res.side = side_c_ff;
   assign res.edge_ok = edge_c_ff;

endmodule

/* rtl/core/rqcf_merge.sv */
// Merging stage: builds the ordered feature mask from the lanes and emits one feature a cycle.
module rqcf_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  rqcf_pkg::lane_res_type lane_res [rqcf_pkg::NUM_LANES],
   output logic                   ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_feature_kind,
   output logic [1:0]             rsp_quad_index,
   output logic [1:0]             rsp_rect_index,
   output logic [4:0]             rsp_feature_number,
   output logic                   rsp_last
);
   import rqcf_pkg::*;

   logic [NUM_SLOTS-1:0] pend_ff, pend_in, pend_left, mask;
   logic                 act_ff, act_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 vld_ff, vld_in;
   slot_type             out_ff, out_in;
   logic [4:0]           num_ff, num_in;
   logic                 last_ff, last_in;
   logic [4:0]           sel;
   logic                 fin, take;
   logic [3:0]           qin, rin;
   logic                 all_q, stop_corner;
   slot_type             cur;

   // Gather the lane results into the fixed emission order.
   always_comb begin
      mask = '0;
      for (int q = 0; q < 4; q++) begin
         qin[q] = &lane_res[q].side;
      end
      for (int r = 0; r < 4; r++) begin
         rin[r] = lane_res[0].edge_ok[r] & lane_res[1].edge_ok[r] &
                  lane_res[2].edge_ok[r] & lane_res[3].edge_ok[r];
      end
      all_q = &qin;
      stop_corner = (qin == 4'd0) && (&rin);
      for (int q = 0; q < 4; q++) begin
         mask[3 - q] = qin[q];
      end
      if (!all_q) begin
         for (int r = 0; r < 4; r++) begin
            mask[SLOT_CORNER_BASE + r] = rin[r];
         end
         if (!stop_corner) begin
            for (int r = 0; r < 4; r++) begin
               for (int q = 0; q < 4; q++) begin
                  mask[SLOT_CROSS_BASE + 4 * r + (3 - q)] =
                     (lane_res[q].side[r] != lane_res[(q + 3) % 4].side[r]) &&
                     (lane_res[q].edge_ok[r] != lane_res[q].edge_ok[(r + 1) % 4]);
               end
            end
         end
      end
      mask[SLOT_NONE] = (mask[SLOT_NONE-1:0] == '0);
   end

   always_comb begin
      sel = 5'd0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = 5'(i);
         end
      end
      pend_left = pend_ff & ~(NUM_SLOTS'(1) << sel);
      cur = slot_info(sel);
      fin = act_ff && (pend_left == '0);
      ready = !act_ff || fin;
      take = in_valid && ready;

      vld_in = act_ff;
      out_in = cur;
      last_in = fin;
      num_in = (cur.kind == KIND_NONE) ? 5'd0 : cnt_ff + 5'd1;

      pend_in = pend_left;
      cnt_in = cnt_ff + 5'd1;
      act_in = act_ff && !fin;
      if (take) begin
         pend_in = mask;
         cnt_in = 5'd0;
         act_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         vld_ff <= vld_in;
      end
      pend_ff <= pend_in;
      cnt_ff <= cnt_in;
      out_ff <= out_in;
      num_ff <= num_in;
      last_ff <= last_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_feature_kind = out_ff.kind;
   assign rsp_quad_index = out_ff.quad_index;
   assign rsp_rect_index = out_ff.rect_index;
   assign rsp_feature_number = num_ff;
   assign rsp_last = last_ff;

endmodule

/* rtl/core/rect_quad_contact_features_core.sv */
// Top level of the rectangle / quadrilateral contact feature core.
//
// An item is taken when start is high and busy is low. It passes three pipeline stages
// (differences, cross products, sign compares) in four parallel lanes, one per quad edge,
// then the merging stage emits its features, one per cycle, on registered result ports,
// with rsp_last on the final one; the stages hold while the merging stage is still busy.
// An item occupies the single result port until its last result is out; the next item may
// enter while the previous one is still being emitted, and its results follow without a
// gap once it has passed the stages. The receiver cannot stall: every result is shown for
// exactly one cycle with rsp_valid high.
module rect_quad_contact_features_core #(
   parameter int COORD_WIDTH = rqcf_pkg::COORD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [30:0] req_rect_half_x,
   input  logic [30:0] req_rect_half_y,
   input  logic [31:0] req_quad0_x,
   input  logic [31:0] req_quad0_y,
   input  logic [31:0] req_quad1_x,
   input  logic [31:0] req_quad1_y,
   input  logic [31:0] req_quad2_x,
   input  logic [31:0] req_quad2_y,
   input  logic [31:0] req_quad3_x,
   input  logic [31:0] req_quad3_y,
   output logic        rsp_valid,
   output logic [1:0]  rsp_feature_kind,
   output logic [1:0]  rsp_quad_index,
   output logic [1:0]  rsp_rect_index,
   output logic [4:0]  rsp_feature_number,
   output logic        rsp_last
);
   import rqcf_pkg::*;

   logic signed [COORD_WIDTH-1:0] qx [NUM_LANES];
   logic signed [COORD_WIDTH-1:0] qy [NUM_LANES];
   logic        [COORD_WIDTH-2:0] hx, hy;
   lane_res_type                  lane_res [NUM_LANES];
   pipe_en_type                   en;
   logic                          va_ff, vb_ff, vc_ff;
   logic                          va_in, vb_in, vc_in;
   logic                          merge_ready, take, accept;

   assign hx = req_rect_half_x[COORD_WIDTH-2:0];
   assign hy = req_rect_half_y[COORD_WIDTH-2:0];
   assign qx[0] = $signed(req_quad0_x[COORD_WIDTH-1:0]);
   assign qy[0] = $signed(req_quad0_y[COORD_WIDTH-1:0]);
   assign qx[1] = $signed(req_quad1_x[COORD_WIDTH-1:0]);
   assign qy[1] = $signed(req_quad1_y[COORD_WIDTH-1:0]);
   assign qx[2] = $signed(req_quad2_x[COORD_WIDTH-1:0]);
   assign qy[2] = $signed(req_quad2_y[COORD_WIDTH-1:0]);
   assign qx[3] = $signed(req_quad3_x[COORD_WIDTH-1:0]);
   assign qy[3] = $signed(req_quad3_y[COORD_WIDTH-1:0]);

   // Each stage advances when the one after it is empty or moving on in the same cycle.
   always_comb begin
      take = vc_ff && merge_ready;
      en.en_c = vb_ff && (!vc_ff || take);
      en.en_b = va_ff && (!vb_ff || en.en_c);
      busy = va_ff && !en.en_b;
      accept = start && !busy;
      en.en_a = accept;
      va_in = accept || (va_ff && !en.en_b);
      vb_in = en.en_b || (vb_ff && !en.en_c);
      vc_in = en.en_c || (vc_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   for (genvar q = 0; q < NUM_LANES; q++) begin : g_lane
      rqcf_lane #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_lane (
         .clock(clock),
         .en(en),
         .qx(qx[q]),
         .qy(qy[q]),
         .px(qx[(q + 3) % NUM_LANES]),
         .py(qy[(q + 3) % NUM_LANES]),
         .hx(hx),
         .hy(hy),
         .res(lane_res[q])
      );
   end

   rqcf_merge u_merge (
      .clock(clock),
      .reset(reset),
      .in_valid(vc_ff),
      .lane_res(lane_res),
      .ready(merge_ready),
      .rsp_valid(rsp_valid),
      .rsp_feature_kind(rsp_feature_kind),
      .rsp_quad_index(rsp_quad_index),
      .rsp_rect_index(rsp_rect_index),
      .rsp_feature_number(rsp_feature_number),
      .rsp_last(rsp_last)
   );

endmodule

/* rtl/core/rqcf_checker.sv */
// Port-level checks on the result stream of the contact feature core, and their bind.
module rqcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [1:0] rsp_feature_kind,
   input logic [4:0] rsp_feature_number,
   input logic       rsp_last
);
   import rqcf_pkg::*;

   // The empty result stands alone and carries no count.
   a_none_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_feature_kind == KIND_NONE |-> rsp_last && rsp_feature_number == 5'd0)
      else $error("none result not alone or with nonzero count");

   a_real_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_feature_kind != KIND_NONE |-> rsp_feature_number != 5'd0)
      else $error("feature result with zero count");

   // The features of one item follow each other without a gap and count up by one.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=>
         rsp_valid && rsp_feature_number == $past(rsp_feature_number) + 5'd1)
      else $error("gap or count slip within one item");

   // Quad vertices, then corners, then crossings.
   a_kind_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_feature_kind >= $past(rsp_feature_kind))
      else $error("feature kinds out of order");

endmodule

bind rect_quad_contact_features_core rqcf_checker u_rqcf_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_feature_kind(rsp_feature_kind),
   .rsp_feature_number(rsp_feature_number),
   .rsp_last(rsp_last)
);

/* tb/tb.sv */
// Self-checking testbench for the rectangle / quadrilateral contact feature core.
`timescale 1ns / 1ps

module tb;
   import rqcf_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_SHOWN = 10;
   localparam int ONE = 65536;
   localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] CMIN = 32'h8000_0000;
   localparam logic [31:0] HMAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] quad_index;
      logic [1:0] rect_index;
      logic [4:0] number;
      logic       last;
   } contact_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [30:0]      half_x;
   logic [30:0]      half_y;
   logic [3:0][31:0] quad_x;
   logic [3:0][31:0] quad_y;
   logic             rsp_valid;
   logic [1:0]       rsp_feature_kind;
   logic [1:0]       rsp_quad_index;
   logic [1:0]       rsp_rect_index;
   logic [4:0]       rsp_feature_number;
   logic             rsp_last;

   contact_type pending_contacts[$];
   int mismatches;
   int quiet_cycles;
   int burst_left;

   rect_quad_contact_features_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_rect_half_x    (half_x),
      .req_rect_half_y    (half_y),
      .req_quad0_x        (quad_x[0]),
      .req_quad0_y        (quad_y[0]),
      .req_quad1_x        (quad_x[1]),
      .req_quad1_y        (quad_y[1]),
      .req_quad2_x        (quad_x[2]),
      .req_quad2_y        (quad_y[2]),
      .req_quad3_x        (quad_x[3]),
      .req_quad3_y        (quad_y[3]),
      .rsp_valid          (rsp_valid),
      .rsp_feature_kind   (rsp_feature_kind),
      .rsp_quad_index     (rsp_quad_index),
      .rsp_rect_index     (rsp_rect_index),
      .rsp_feature_number (rsp_feature_number),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lists the contacts of one rectangle / quad pair in emission order.
   function automatic void predict_contacts(input logic [30:0] hx_in, input logic [30:0] hy_in,
                                            input logic [3:0][31:0] qx_in,
                                            input logic [3:0][31:0] qy_in);
      longint hx, hy;
      longint qx[4], qy[4], rx[4], ry[4];
      bit side[4][4];
      bit edge_ok[4][4];
      bit vert_in[4];
      bit corner_in[4];
      bit no_quad;
      logic signed [67:0] dqx, dqy, drx, dry;
      contact_type features[$];
      int p;
      hx = longint'(hx_in);
      hy = longint'(hy_in);
      for (int q = 0; q < 4; q++) begin
         qx[q] = longint'($signed(qx_in[q]));
         qy[q] = longint'($signed(qy_in[q]));
      end
      rx[0] = hx;  ry[0] = hy;
      rx[1] = -hx; ry[1] = hy;
      rx[2] = -hx; ry[2] = -hy;
      rx[3] = hx;  ry[3] = -hy;
      for (int q = 0; q < 4; q++) begin
         side[0][q] = qy[q] <= hy;
         side[1][q] = qx[q] >= -hx;
         side[2][q] = qy[q] >= -hy;
         side[3][q] = qx[q] <= hx;
         vert_in[q] = side[0][q] && side[1][q] && side[2][q] && side[3][q];
      end
      for (int q = 3; q >= 0; q--) begin
         if (vert_in[q])
            features.insert(features.size(),
                            {KIND_QUAD, 2'(q), 2'd0, 5'(features.size() + 1), 1'b0});
      end
      if (features.size() != 4) begin
         for (int r = 0; r < 4; r++) corner_in[r] = 1'b1;
         for (int q = 0; q < 4; q++) begin
            p = (q + 3) % 4;
            dqx = qx[p] - qx[q];
            dqy = qy[p] - qy[q];
            for (int r = 0; r < 4; r++) begin
               drx = rx[r] - qx[q];
               dry = ry[r] - qy[q];
               // The products need up to 65 bits, so they are formed at 68.
               edge_ok[q][r] = (dqx * dry) >= (dqy * drx);
               if (!edge_ok[q][r]) corner_in[r] = 1'b0;
            end
         end
         no_quad = features.size() == 0;
         for (int r = 0; r < 4; r++) begin
            if (corner_in[r])
               features.insert(features.size(),
                               {KIND_CORNER, 2'd0, 2'(r), 5'(features.size() + 1), 1'b0});
         end
         if (!(no_quad && features.size() == 4)) begin
            for (int r = 0; r < 4; r++) begin
               for (int q = 3; q >= 0; q--) begin
                  p = (q + 3) % 4;
                  if (side[r][q] != side[r][p] && edge_ok[q][r] != edge_ok[q][(r + 1) % 4])
                     features.insert(features.size(),
                                     {KIND_CROSS, 2'(p), 2'(r),
                                      5'(features.size() + 1), 1'b0});
               end
            end
         end
      end
      if (features.size() == 0)
         features.insert(0, {KIND_NONE, 2'd0, 2'd0, 5'd0, 1'b0});
      features[features.size() - 1].last = 1'b1;
      foreach (features[i]) pending_contacts.insert(pending_contacts.size(), features[i]);
   endfunction

   task automatic report_contact(input string reason, input contact_type want,
                                 input contact_type got);
      if (mismatches < MAX_SHOWN)
         $display("%0t: %s: expected kind %0d quad %0d rect %0d number %0d last %0d,",
                  $realtime, reason, want.kind, want.quad_index, want.rect_index, want.number,
                  want.last, " got kind %0d quad %0d rect %0d number %0d last %0d",
                  got.kind, got.quad_index, got.rect_index, got.number, got.last);
      mismatches++;
   endtask

   // Checks results, predicts accepted items and watches for a hang.
   always @(posedge clock) begin
      contact_type want;
      contact_type got;
      got = {rsp_feature_kind, rsp_quad_index, rsp_rect_index, rsp_feature_number, rsp_last};
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_contacts.size() == 0) begin
               report_contact("result with nothing pending", '0, got);
            end else begin
               want = pending_contacts.pop_front();
               if (got.kind !== want.kind || got.quad_index !== want.quad_index ||
                   got.rect_index !== want.rect_index || got.number !== want.number ||
                   got.last !== want.last)
                  report_contact("contact mismatch", want, got);
            end
         end
         if (start && !busy)
            predict_contacts(half_x, half_y, quad_x, quad_y);
         if (rsp_valid || (start && !busy))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Entered and left at a falling edge; start stays high when the next item follows at once.
   task automatic send_pair(input logic [31:0] hx, input logic [31:0] hy,
                            input logic [31:0] x0, input logic [31:0] y0,
                            input logic [31:0] x1, input logic [31:0] y1,
                            input logic [31:0] x2, input logic [31:0] y2,
                            input logic [31:0] x3, input logic [31:0] y3);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 13);
         if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 30);
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      half_x = hx[30:0];
      half_y = hy[30:0];
      quad_x = {x3, x2, x1, x0};
      quad_y = {y3, y2, y1, y0};
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic int pick_coord(input int h, input int span);
      case ($urandom_range(0, 7))
         0: return h;
         1: return -h;
         2: return 0;
         default: return int'($urandom_range(0, 4 * span)) - 2 * span;
      endcase
   endfunction

   task automatic test_directed();
      // All quad vertices inside: emission ends after the quad vertices.
      send_pair(4 * ONE, 4 * ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE, -ONE, ONE);
      // Rectangle inside a clockwise quad: emission ends after the corners.
      send_pair(ONE, ONE, 4 * ONE, 4 * ONE, 4 * ONE, -4 * ONE, -4 * ONE, -4 * ONE,
                -4 * ONE, 4 * ONE);
      // Same quad wound the other way.
      send_pair(ONE, ONE, 4 * ONE, 4 * ONE, -4 * ONE, 4 * ONE, -4 * ONE, -4 * ONE,
                4 * ONE, -4 * ONE);
      // Far away: nothing found.
      send_pair(ONE, ONE, 100 * ONE, 100 * ONE, 101 * ONE, 100 * ONE, 101 * ONE, 101 * ONE,
                100 * ONE, 101 * ONE);
      // Vertices exactly on a corner and on an edge of the rectangle.
      send_pair(2 * ONE, 3 * ONE, 2 * ONE, 3 * ONE, 9 * ONE, 9 * ONE, 9 * ONE, 8 * ONE,
                8 * ONE, 8 * ONE);
      send_pair(2 * ONE, 3 * ONE, 2 * ONE, 0, 9 * ONE, 0, 9 * ONE, -ONE, 5 * ONE, -ONE);
      send_pair(2 * ONE, 3 * ONE, -2 * ONE, -3 * ONE, 9 * ONE, 9 * ONE, 9 * ONE, -9 * ONE,
                -9 * ONE, -9 * ONE);
      // Zero extents.
      send_pair(0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, -ONE, ONE);
      send_pair(0, 0, 0, 0, ONE, ONE, ONE, 0, 0, ONE);
      // Largest extents against the coordinate extremes.
      send_pair(HMAX, HMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX);
      send_pair(HMAX, HMAX, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(HMAX, HMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
      send_pair(HMAX, 0, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
      // Edge crossings only: a thin bar and a diamond.
      send_pair(2 * ONE, 2 * ONE, 5 * ONE, ONE, 5 * ONE, -ONE, -5 * ONE, -ONE, -5 * ONE, ONE);
      send_pair(2 * ONE, 2 * ONE, 0, 3 * ONE, 3 * ONE, 0, 0, -3 * ONE, -3 * ONE, 0);
      // Partial overlap mixing all three kinds.
      send_pair(2 * ONE, 2 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, ONE, ONE, ONE, ONE, 5 * ONE);
      send_pair(2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE, -ONE, -ONE, -ONE, -ONE, 3 * ONE);
      // Degenerate quads: one repeated point inside and outside, a bow tie, a thin nearly flat quad.
      send_pair(2 * ONE, 2 * ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
      send_pair(2 * ONE, 2 * ONE, 7 * ONE, 7 * ONE, 7 * ONE, 7 * ONE, 7 * ONE, 7 * ONE,
                7 * ONE, 7 * ONE);
      send_pair(2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, -3 * ONE, -3 * ONE, 3 * ONE, -3 * ONE,
                -3 * ONE, 3 * ONE);
      send_pair(2 * ONE, 2 * ONE, -5 * ONE, -4 * ONE, -ONE, 0, ONE, ONE, 5 * ONE, 4 * ONE);
   endtask

   // Jittered boxes around the rectangle, mostly clockwise so corners can fall inside.
   task automatic test_structured_quads(input int count);
      int hx, hy, span, cx, cy, k;
      int ax[4], ay[4], vx[4], vy[4];
      for (int i = 0; i < count; i++) begin
         hx = $urandom_range(0, 1 << 22);
         hy = $urandom_range(0, 1 << 22);
         span = hx + hy + 1;
         cx = int'($urandom_range(0, 2 * span)) - span;
         cy = int'($urandom_range(0, 2 * span)) - span;
         for (int j = 0; j < 4; j++) begin
            ax[j] = $urandom_range(0, 2 * span);
            ay[j] = $urandom_range(0, 2 * span);
         end
         vx[0] = cx + ax[0]; vy[0] = cy + ay[0];
         vx[1] = cx + ax[1]; vy[1] = cy - ay[1];
         vx[2] = cx - ax[2]; vy[2] = cy - ay[2];
         vx[3] = cx - ax[3]; vy[3] = cy + ay[3];
         if ($urandom_range(0, 3) == 0) begin
            k = vx[1]; vx[1] = vx[3]; vx[3] = k;
            k = vy[1]; vy[1] = vy[3]; vy[3] = k;
         end
         if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, 3);
            vx[k] = $urandom_range(0, 1) ? hx : -hx;
            vy[k] = $urandom_range(0, 1) ? hy : -hy;
         end
         send_pair(hx, hy, vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], vx[3], vy[3]);
      end
   endtask

   // Unordered points near the rectangle, often on its border lines.
   task automatic test_scattered_points(input int count);
      int hx, hy, span;
      int vx[4], vy[4];
      for (int i = 0; i < count; i++) begin
         hx = $urandom_range(0, 1 << 20);
         hy = $urandom_range(0, 1 << 20);
         span = hx + hy + 1;
         for (int j = 0; j < 4; j++) begin
            vx[j] = pick_coord(hx, span);
            vy[j] = pick_coord(hy, span);
         end
         send_pair(hx, hy, vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], vx[3], vy[3]);
      end
   endtask

   task automatic test_full_range(input int count);
      for (int i = 0; i < count; i++)
         send_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      half_x = '0;
      half_y = '0;
      quad_x = '0;
      quad_y = '0;
      mismatches = 0;
      quiet_cycles = 0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_structured_quads(270);
      test_scattered_points(70);
      test_full_range(50);
      start = 1'b0;
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
